FILE: rtl/pldvd_pkg.sv
// Shared types and constants for the posting list delta variable-byte decoder.
// Used by the decode core, the top level and the port checker.
package pldvd_pkg;

    // Width of every decoded value, document id and frequency.
    localparam int VALUE_W = 32;

    // Default limit on the number of bytes in one code.
    localparam int MAX_CODE_BYTES_DEF = 5;

    // Payload bits of a code byte and the bit that marks the last byte.
    localparam logic [6:0] GROUP_MASK = 7'h7F;
    localparam int GROUP_W = 7;
    localparam int STOP_BIT = 7;

    // Decoder phase: which value the next completed code is.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DELTA  = 2'd1,
        PH_FREQ   = 2'd2
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_POSTING  = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    // One result word as it leaves the decode core.
    typedef struct packed {
        logic [VALUE_W-1:0] doc_id;
        logic [VALUE_W-1:0] frequency;
        status_t            status;
        logic               last_of_list;
    } result_t;

    // Handshake from the decode core back to the top level.
    typedef struct packed {
        logic    valid;
        result_t data;
    } core_out_t;

endpackage

FILE: rtl/pldvd_decode_core.sv
// Decode core: holds the list state and consumes one code byte per fire.
// Depends on pldvd_pkg for phase, status and result types.
module pldvd_decode_core #(
    parameter int MAX_CODE_BYTES = pldvd_pkg::MAX_CODE_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            code_byte,
    input  logic                  end_of_buffer,
    output pldvd_pkg::core_out_t  core_out
);

    localparam int GW = (MAX_CODE_BYTES > 1) ? $clog2(MAX_CODE_BYTES) : 1;
    localparam int SHIFT_W = $clog2(pldvd_pkg::GROUP_W * (MAX_CODE_BYTES - 1) + 1);
    localparam int VW = pldvd_pkg::VALUE_W;

    pldvd_pkg::phase_t phase_reg, phase_next;
    logic [VW-1:0]     accum_reg, accum_next;
    logic [GW-1:0]     group_reg, group_next;
    logic [VW-1:0]     left_reg, left_next;
    logic [VW-1:0]     prev_reg, prev_next;
    logic [VW-1:0]     pending_reg, pending_next;

    logic [SHIFT_W-1:0] shamt;
    logic [VW-1:0]      group_bits;
    logic [VW-1:0]      merged;
    logic [GW:0]        group_inc;
    logic [VW-1:0]      left_dec;
    logic               go_header;

    // Place the new 7-bit group; groups at or above bit 32 fall off the top.
    always_comb
    begin
        shamt      = SHIFT_W'(int'(group_reg) * pldvd_pkg::GROUP_W);
        group_bits = VW'(code_byte[6:0] & pldvd_pkg::GROUP_MASK) << shamt;
        merged     = accum_reg | group_bits;
        group_inc  = {1'b0, group_reg} + (GW+1)'(1);
        left_dec   = left_reg - VW'(1);
    end

    // Next state and result for one byte.
    always_comb
    begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        group_next    = group_reg;
        left_next     = left_reg;
        prev_next     = prev_reg;
        pending_next  = pending_reg;
        go_header     = 1'b0;
        core_out      = '0;

        if (fire)
        begin
            if (!code_byte[pldvd_pkg::STOP_BIT])
            begin
                // Value continues in the next byte.
                accum_next = merged;
                group_next = group_inc[GW-1:0];
                if (group_inc >= (GW+1)'(MAX_CODE_BYTES))
                begin
                    go_header                   = 1'b1;
                    core_out.valid              = 1'b1;
                    core_out.data.status        = pldvd_pkg::ST_OVERFLOW;
                    core_out.data.last_of_list  = 1'b1;
                end
                else if (end_of_buffer)
                begin
                    go_header                   = 1'b1;
                    core_out.valid              = 1'b1;
                    core_out.data.status        = pldvd_pkg::ST_TRUNC;
                    core_out.data.last_of_list  = 1'b1;
                end
            end
            else
            begin
                // A value is complete.
                accum_next = '0;
                group_next = '0;
                case (phase_reg)
                    pldvd_pkg::PH_HEADER:
                    begin
                        if (merged == '0)
                        begin
                            go_header                   = 1'b1;
                            core_out.valid              = 1'b1;
                            core_out.data.status        = pldvd_pkg::ST_EMPTY;
                            core_out.data.last_of_list  = 1'b1;
                        end
                        else
                        begin
                            left_next  = merged;
                            prev_next  = '0;
                            phase_next = pldvd_pkg::PH_DELTA;
                            if (end_of_buffer)
                            begin
                                go_header                   = 1'b1;
                                core_out.valid              = 1'b1;
                                core_out.data.status        = pldvd_pkg::ST_TRUNC;
                                core_out.data.last_of_list  = 1'b1;
                            end
                        end
                    end
                    pldvd_pkg::PH_DELTA:
                    begin
                        pending_next = prev_reg + merged;
                        phase_next   = pldvd_pkg::PH_FREQ;
                        if (end_of_buffer)
                        begin
                            go_header                   = 1'b1;
                            core_out.valid              = 1'b1;
                            core_out.data.status        = pldvd_pkg::ST_TRUNC;
                            core_out.data.last_of_list  = 1'b1;
                        end
                    end
                    pldvd_pkg::PH_FREQ:
                    begin
                        // Frequency closes a posting; the list may end here.
                        prev_next                  = pending_reg;
                        left_next                  = left_dec;
                        phase_next                 = pldvd_pkg::PH_DELTA;
                        core_out.valid             = 1'b1;
                        core_out.data.doc_id       = pending_reg;
                        core_out.data.frequency    = merged;
                        core_out.data.status       = pldvd_pkg::ST_POSTING;
                        core_out.data.last_of_list = (left_dec == '0) || end_of_buffer;
                        go_header                  = (left_dec == '0) || end_of_buffer;
                    end
                    default:
                    begin
                        go_header = 1'b1;
                    end
                endcase
            end

            // Closing a list returns every field to its header value.
            if (go_header)
            begin
                phase_next   = pldvd_pkg::PH_HEADER;
                accum_next   = '0;
                group_next   = '0;
                left_next    = '0;
                prev_next    = '0;
                pending_next = '0;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= pldvd_pkg::PH_HEADER;
            accum_reg   <= '0;
            group_reg   <= '0;
            left_reg    <= '0;
            prev_reg    <= '0;
            pending_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            group_reg   <= group_next;
            left_reg    <= left_next;
            prev_reg    <= prev_next;
            pending_reg <= pending_next;
        end
    end

endmodule

FILE: rtl/posting_list_delta_vbyte_decoder_top.sv
// Top level of the posting list decoder: input register, decode core, result register.
// Depends on pldvd_pkg and pldvd_decode_core.
//
//   Channel  | Handshake                  | Word
//   ---------+----------------------------+-----------------------------------------
//   code     | code_valid / code_stall    | code_byte, end_of_buffer
//   result   | result_valid / result_stall| doc_id, frequency, status, last_of_list
//
// One byte is taken per cycle while code_stall is low, a rate set by the decode core's state
// update; each byte is held in the input register and its result in the result register.
// Reset returns the decoder to expecting a count header and empties both registers.
// A stall on the result side holds the byte in the input register; the code side
// stalls only while that register is full and the result register is held.
module posting_list_delta_vbyte_decoder_top #(
    parameter int MAX_CODE_BYTES = pldvd_pkg::MAX_CODE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        code_valid,
    output logic        code_stall,
    input  logic [7:0]  code_byte,
    input  logic        end_of_buffer,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] doc_id,
    output logic [31:0] frequency,
    output logic [1:0]  status,
    output logic        last_of_list
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 in_eob_reg;
    logic                 out_valid_reg, out_valid_next;
    pldvd_pkg::result_t   out_data_reg;
    pldvd_pkg::core_out_t core_out;
    logic                 out_free;
    logic                 fire;
    logic                 accept;

    // Handshake control.
    always_comb
    begin
        out_free       = !out_valid_reg || !result_stall;
        fire           = in_valid_reg && out_free;
        code_stall     = in_valid_reg && !fire;
        accept         = code_valid && !code_stall;
        in_valid_next  = accept || (in_valid_reg && !fire);
        out_valid_next = out_free ? (fire && core_out.valid) : out_valid_reg;
    end

    pldvd_decode_core #(
        .MAX_CODE_BYTES (MAX_CODE_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .code_byte     (in_byte_reg),
        .end_of_buffer (in_eob_reg),
        .core_out      (core_out)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= code_byte;
            in_eob_reg  <= end_of_buffer;
        end
        if (fire && core_out.valid)
        begin
            out_data_reg <= core_out.data;
        end
    end

    // Result ports.
    assign result_valid = out_valid_reg;
    assign doc_id       = out_data_reg.doc_id;
    assign frequency    = out_data_reg.frequency;
    assign status       = out_data_reg.status;
    assign last_of_list = out_data_reg.last_of_list;

endmodule

FILE: rtl/pldvd_port_checker.sv
// Port checker for the posting list decoder, attached by bind to the top level.
// Depends on pldvd_pkg for status codes.
module pldvd_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        code_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] doc_id,
    input logic [31:0] frequency,
    input logic [1:0]  status,
    input logic        last_of_list
);

    // A held result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    // Every status other than a posting closes the list.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != pldvd_pkg::ST_POSTING) |-> last_of_list)
        else $error("non-posting result without last_of_list");

    // Status words carry no document id or frequency.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != pldvd_pkg::ST_POSTING)
        |-> (doc_id == 32'd0) && (frequency == 32'd0))
        else $error("non-posting result carries data");

    // The code side waits only behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_stall |-> result_valid && result_stall)
        else $error("code side stalled without a held result");

endmodule

bind posting_list_delta_vbyte_decoder_top pldvd_port_checker u_port_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .code_stall   (code_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .doc_id       (doc_id),
    .frequency    (frequency),
    .status       (status),
    .last_of_list (last_of_list)
);
